// File: rtl/vrf_pkg.sv
// ----------------------------------------------------------------------------
// vrf_pkg
// Shared types and constants for the variable-length record ring FIFO.
// ----------------------------------------------------------------------------
package vrf_pkg;

  // default store depth in 32-bit words
  localparam int DEPTH_WORDS_DEF = 256;

  // fixed field widths
  localparam int OP_W     = 3;
  localparam int ID_W     = 16;
  localparam int BYTES_W  = 10;
  localparam int WORD_W   = 32;
  localparam int OFS_W    = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;
  localparam int SIZE_W   = 11;

  // record size in words: payload words plus header, up to 257
  localparam int RECW_W   = 9;

  // header queue entry: id over byte count
  localparam int HDR_W    = ID_W + BYTES_W;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_BEGIN = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_WORD  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK       = 3'd2;
  localparam logic [OP_W-1:0] OP_POP        = 3'd3;
  localparam logic [OP_W-1:0] OP_READ       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD     = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    opcode;
    logic [ID_W-1:0]    event_id;
    logic [BYTES_W-1:0] payload_bytes;
    logic [WORD_W-1:0]  data_word;
    logic [OFS_W-1:0]   word_offset;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     head_id;
    logic [BYTES_W-1:0]  head_bytes;
    logic [WORD_W-1:0]   read_word;
    logic [COUNT_W-1:0]  record_count;
    logic [SIZE_W-1:0]   bytes_used;
    logic [SIZE_W-1:0]   bytes_free;
  } out_item_t;

  // payload words of a record of the given byte count
  function automatic logic [RECW_W-1:0] payload_words(input logic [BYTES_W-1:0] nbytes);
    logic [BYTES_W:0] sum;
    sum = {1'b0, nbytes} + (BYTES_W+1)'(3);
    return RECW_W'(sum >> 2);
  endfunction

endpackage

// File: rtl/vrf_ram.sv
// ----------------------------------------------------------------------------
// vrf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vrf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/variable_record_ring_fifo.sv
// ----------------------------------------------------------------------------
// variable_record_ring_fifo
// Ring FIFO of variable-length records held in a word store, with a header
// queue that keeps the head record's id and byte count at hand.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one operation per transfer (push begin, push
//   payload word, peek, pop, read payload word); out_valid/out_ready return
//   exactly one result per operation, in order, with status and occupancy.
//   An operation lands in the input register on its transfer, is evaluated
//   there and its result is registered as it leaves; read_word comes from
//   the word store's registered read port alongside that result register.
//   Throughput: one operation per cycle while the result register is not
//   stalled by out_ready; the head header queue reads the record after the
//   head ahead of time so back-to-back pops need no wait.
//   When out_ready is low the result register holds, the input register
//   holds its operation, and in_ready drops once both are full.
//   Reset (rst_n low, synchronous) empties the FIFO and clears the wrap
//   mark; store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module variable_record_ring_fifo #(
  parameter int DEPTH_WORDS = vrf_pkg::DEPTH_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vrf_pkg::out_item_t out_data
);

  // index widths: AW addresses the store, PW also holds DEPTH_WORDS itself
  localparam int AW = $clog2(DEPTH_WORDS);
  localparam int PW = $clog2(DEPTH_WORDS + 1);
  localparam int XW = ((PW > vrf_pkg::RECW_W) ? PW : vrf_pkg::RECW_W) + 1;
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH_WORDS);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH_WORDS - 1);
  // zero bits between id and byte count in a stored header word
  localparam int PADW = vrf_pkg::WORD_W - vrf_pkg::HDR_W;

  // input register
  logic              a_valid_r;
  vrf_pkg::in_item_t a_item_r;
  logic              a_adv;

  // fifo state
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] wrap_r, wrap_nxt;
  logic [PW-1:0] count_r, count_nxt;
  logic [PW-1:0] used_r, used_nxt;
  logic [PW-1:0] pend_r, pend_nxt;
  logic [PW-1:0] widx_r, widx_nxt;
  logic [AW-1:0] hr_ptr_r, hr_ptr_nxt;
  logic [AW-1:0] hw_ptr_r, hw_ptr_nxt;
  logic [vrf_pkg::HDR_W-1:0] head_hdr_r, head_hdr_nxt;

  // header queue bypass for a write to the address being read
  logic                      byp_valid_r;
  logic [vrf_pkg::HDR_W-1:0] byp_data_r;

  // result register
  logic                         b_valid_r;
  logic                         b_rd_r, b_rd_nxt;
  logic [vrf_pkg::STATUS_W-1:0] b_status_r, status_c;
  logic [vrf_pkg::ID_W-1:0]     b_hid_r, hid_c;
  logic [vrf_pkg::BYTES_W-1:0]  b_hbytes_r, hbytes_c;
  logic [PW-1:0]                b_count_r, b_used_r, b_free_r, free_after;
  logic                         b_ready;

  // store ports
  logic                      word_we, word_re;
  logic [AW-1:0]             word_waddr, word_raddr;
  logic [vrf_pkg::WORD_W-1:0] word_wdata;
  logic [vrf_pkg::WORD_W-1:0] word_q;
  logic                      hdr_we;
  logic [AW-1:0]             hdr_raddr;
  logic [vrf_pkg::HDR_W-1:0] hdr_wdata, hdr_q, second_hdr;

  // largest contiguous free run in words
  function automatic logic [PW-1:0] free_fn(input logic [PW-1:0] h,
                                            input logic [PW-1:0] t,
                                            input logic [PW-1:0] c);
    logic [PW-1:0] end_w;
    end_w = DEPTH_P - t;
    if (t > h || (t == h && c == '0)) begin
      return (h > end_w) ? h : end_w;
    end
    return h - t;
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_A) ? '0 : p + AW'(1);
  endfunction

  // handshake
  assign b_ready  = !b_valid_r || out_ready;
  assign a_adv    = a_valid_r && b_ready;
  assign in_ready = !a_valid_r || a_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_item_r <= in_data;
    end
  end

  assign second_hdr = byp_valid_r ? byp_data_r : hdr_q;

  // operation evaluation
  always_comb begin
    logic [vrf_pkg::RECW_W-1:0] total;
    logic [vrf_pkg::RECW_W-1:0] pw;
    logic [PW-1:0]              h;
    logic [PW-1:0]              t0;
    logic [PW-1:0]              free_now;
    logic [XW-1:0]              sum_x;
    logic [XW-1:0]              raddr_x;

    head_nxt     = head_r;
    tail_nxt     = tail_r;
    wrap_nxt     = wrap_r;
    count_nxt    = count_r;
    used_nxt     = used_r;
    pend_nxt     = pend_r;
    widx_nxt     = widx_r;
    hr_ptr_nxt   = hr_ptr_r;
    hw_ptr_nxt   = hw_ptr_r;
    head_hdr_nxt = head_hdr_r;
    status_c     = vrf_pkg::ST_OK;
    hid_c        = '0;
    hbytes_c     = '0;
    b_rd_nxt     = 1'b0;
    word_we      = 1'b0;
    word_re      = 1'b0;
    word_waddr   = widx_r[AW-1:0];
    word_wdata   = a_item_r.data_word;
    word_raddr   = '0;
    hdr_we       = 1'b0;
    hdr_wdata    = {a_item_r.event_id, a_item_r.payload_bytes};
    total        = '0;
    pw           = '0;
    h            = (head_r == wrap_r) ? '0 : head_r;
    t0           = tail_r;
    free_now     = free_fn(head_r, tail_r, count_r);
    sum_x        = '0;
    raddr_x      = '0;

    if (a_adv) begin
      unique case (a_item_r.opcode)
        // push begin: reserve the record and queue its header
        vrf_pkg::OP_PUSH_BEGIN: begin
          total = vrf_pkg::payload_words(a_item_r.payload_bytes) + vrf_pkg::RECW_W'(1);
          if (pend_r != '0) begin
            status_c = vrf_pkg::ST_BAD;
          end else if (XW'(free_now) < XW'(total)) begin
            status_c = vrf_pkg::ST_NO_ROOM;
          end else begin
            sum_x = XW'(tail_r) + XW'(total);
            if (sum_x > XW'(DEPTH_WORDS)) begin
              wrap_nxt = tail_r;
              t0       = '0;
            end
            // header word also lands in the word store
            word_we    = (t0 < DEPTH_P);
            word_waddr = t0[AW-1:0];
            word_wdata = {a_item_r.event_id, {PADW{1'b0}}, a_item_r.payload_bytes};
            widx_nxt   = t0 + PW'(1);
            pend_nxt   = PW'(total - vrf_pkg::RECW_W'(1));
            tail_nxt   = PW'(XW'(t0) + XW'(total));
            count_nxt  = count_r + PW'(1);
            used_nxt   = PW'(XW'(used_r) + XW'(total));
            hdr_we     = 1'b1;
            hw_ptr_nxt = ptr_inc(hw_ptr_r);
            if (count_r == '0) begin
              head_hdr_nxt = hdr_wdata;
            end
          end
        end
        // payload word into the reserved record
        vrf_pkg::OP_PUSH_WORD: begin
          if (pend_r == '0) begin
            status_c = vrf_pkg::ST_BAD;
          end else begin
            word_we  = (widx_r < DEPTH_P);
            widx_nxt = widx_r + PW'(1);
            pend_nxt = pend_r - PW'(1);
          end
        end
        // head access: peek, pop, read
        vrf_pkg::OP_PEEK, vrf_pkg::OP_POP, vrf_pkg::OP_READ: begin
          if (count_r == '0) begin
            status_c = vrf_pkg::ST_EMPTY;
          end else begin
            if (head_r == wrap_r) begin
              head_nxt = '0;
              wrap_nxt = DEPTH_P;
            end
            if (a_item_r.opcode == vrf_pkg::OP_READ) begin
              pw = vrf_pkg::payload_words(head_hdr_r[vrf_pkg::BYTES_W-1:0]);
              if (vrf_pkg::RECW_W'(a_item_r.word_offset) >= pw) begin
                status_c = vrf_pkg::ST_BAD;
              end else begin
                raddr_x    = XW'(h) + XW'(1) + XW'(a_item_r.word_offset);
                b_rd_nxt   = (raddr_x < XW'(DEPTH_WORDS));
                word_re    = b_rd_nxt;
                word_raddr = raddr_x[AW-1:0];
              end
            end else begin
              hid_c    = head_hdr_r[vrf_pkg::HDR_W-1:vrf_pkg::BYTES_W];
              hbytes_c = head_hdr_r[vrf_pkg::BYTES_W-1:0];
              if (a_item_r.opcode == vrf_pkg::OP_POP) begin
                total = vrf_pkg::payload_words(hbytes_c) + vrf_pkg::RECW_W'(1);
                head_nxt     = PW'(XW'(h) + XW'(total));
                count_nxt    = count_r - PW'(1);
                used_nxt     = (XW'(used_r) >= XW'(total)) ? PW'(XW'(used_r) - XW'(total))
                                                           : '0;
                hr_ptr_nxt   = ptr_inc(hr_ptr_r);
                head_hdr_nxt = second_hdr;
              end
            end
          end
        end
        default: begin
          status_c = vrf_pkg::ST_BAD;
        end
      endcase
    end

    free_after = free_fn(head_nxt, tail_nxt, count_nxt);
    hdr_raddr  = ptr_inc(hr_ptr_nxt);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      wrap_r      <= DEPTH_P;
      count_r     <= '0;
      used_r      <= '0;
      pend_r      <= '0;
      widx_r      <= '0;
      hr_ptr_r    <= '0;
      hw_ptr_r    <= '0;
      byp_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      wrap_r      <= wrap_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      widx_r      <= widx_nxt;
      hr_ptr_r    <= hr_ptr_nxt;
      hw_ptr_r    <= hw_ptr_nxt;
      byp_valid_r <= hdr_we && (hw_ptr_r == hdr_raddr);
    end
  end

  always_ff @(posedge clk) begin
    head_hdr_r <= head_hdr_nxt;
    byp_data_r <= hdr_wdata;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_status_r <= status_c;
      b_hid_r    <= hid_c;
      b_hbytes_r <= hbytes_c;
      b_rd_r     <= b_rd_nxt;
      b_count_r  <= count_nxt;
      b_used_r   <= used_nxt;
      b_free_r   <= free_after;
    end
  end

  assign out_valid             = b_valid_r;
  assign out_data.status       = b_status_r;
  assign out_data.head_id      = b_hid_r;
  assign out_data.head_bytes   = b_hbytes_r;
  assign out_data.read_word    = b_rd_r ? word_q : '0;
  assign out_data.record_count = vrf_pkg::COUNT_W'(b_count_r);
  assign out_data.bytes_used   = vrf_pkg::SIZE_W'({b_used_r, 2'b00});
  assign out_data.bytes_free   = vrf_pkg::SIZE_W'({b_free_r, 2'b00});

  // record word store, headers and payload words
  vrf_ram #(
    .WIDTH (vrf_pkg::WORD_W),
    .DEPTH (DEPTH_WORDS)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (word_re),
    .raddr (word_raddr),
    .rdata (word_q)
  );

  // header queue, read one record ahead of the head
  vrf_ram #(
    .WIDTH (vrf_pkg::HDR_W),
    .DEPTH (DEPTH_WORDS)
  ) u_hdr_ram (
    .clk   (clk),
    .we    (hdr_we),
    .waddr (hw_ptr_r),
    .wdata (hdr_wdata),
    .re    (1'b1),
    .raddr (hdr_raddr),
    .rdata (hdr_q)
  );

  // header queue occupancy matches the record count
  logic [AW:0] hq_diff;
  assign hq_diff = (hw_ptr_r >= hr_ptr_r) ? {1'b0, hw_ptr_r} - {1'b0, hr_ptr_r}
                                          : {1'b0, hw_ptr_r} + (AW+1)'(DEPTH_WORDS)
                                            - {1'b0, hr_ptr_r};

  a_hq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r < DEPTH_P) |-> (PW'(hq_diff) == count_r))
    else $error("header queue occupancy differs from record count");

  a_empty_used: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (used_r == '0))
    else $error("words in use with no records held");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_P)
    else $error("used words exceed store depth");

  a_word_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(word_we && word_re))
    else $error("word store written and read by one operation");

  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && b_rd_r) |-> (b_status_r == vrf_pkg::ST_OK))
    else $error("payload read returned with a failing status");

endmodule
